>>> design/kmcs_pkg.sv
// Shared types and constants of the key matrix change scanner.
// No dependencies; imported by every module of the block.
package kmcs_pkg;

  localparam int SENSE_W    = 18;
  localparam int ROW_IDX_W  = 4;
  localparam int LINE_IDX_W = 5;
  localparam int DRIVE_W    = 16;
  localparam int MAX_LINES  = 32;

  localparam logic [7:0]         DRIVE_BASE   = 8'd128;
  localparam logic [DRIVE_W-1:0] DRIVE_INVERT = 16'hFF80;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROWEND
  } kmcs_state_t;

  typedef struct packed {
    logic write;
    logic advance;
  } kmcs_store_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
  } kmcs_walk_ctrl_t;

  typedef struct packed {
    logic none_left;
    logic hit;
    logic level;
  } kmcs_walk_stat_t;

  // active-low drive pattern for a row, truncated to 16 bits
  function automatic logic [DRIVE_W-1:0] drive_for(input logic [ROW_IDX_W-1:0] row);
    logic [31:0] onehot;
    onehot = 32'(DRIVE_BASE) << row;
    return DRIVE_W'(onehot) ^ DRIVE_INVERT;
  endfunction

endpackage

>>> design/kmcs_level_store.sv
// Per-row key level store and current row counter.
// Depends on kmcs_pkg.
module kmcs_level_store import kmcs_pkg::*; #(
  parameter int NUM_ROWS  = 9,
  parameter int NUM_LINES = 18,
  localparam int ROW_W    = $clog2(NUM_ROWS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kmcs_store_ctrl_t     ctrl,
  input  logic [NUM_LINES-1:0] new_levels,
  output logic [NUM_LINES-1:0] old_levels,
  output logic [ROW_W-1:0]     row
);

  logic [NUM_LINES-1:0] levels [NUM_ROWS];

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      for (int i = 0; i < NUM_ROWS; i++) begin
        levels[i] <= '0;
      end
    end else begin
      if (ctrl.write) begin
        levels[row] <= new_levels;
      end
      if (ctrl.advance) begin
        row <= (row == ROW_W'(NUM_ROWS - 1)) ? '0 : row + ROW_W'(1);
      end
    end
  end

  assign old_levels = levels[row];

endmodule

>>> design/kmcs_line_walker.sv
// Shift unit that walks the changed-line word one sense line per cycle while step is asserted.
// Depends on kmcs_pkg.
module kmcs_line_walker import kmcs_pkg::*; #(
  parameter int NUM_LINES = 18,
  localparam int LINE_W   = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1
) (
  input  logic                 clk,
  input  kmcs_walk_ctrl_t      ctrl,
  input  logic [NUM_LINES-1:0] new_levels,
  input  logic [NUM_LINES-1:0] old_levels,
  output kmcs_walk_stat_t      stat,
  output logic [LINE_W-1:0]    line
);

  logic [NUM_LINES-1:0] diff;
  logic [NUM_LINES-1:0] levels;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      diff   <= new_levels ^ old_levels;
      levels <= new_levels;
      line   <= '0;
    end else if (ctrl.step) begin
      diff   <= diff >> 1;
      levels <= levels >> 1;
      line   <= line + LINE_W'(1);
    end
  end

  assign stat.none_left = (diff == '0);
  assign stat.hit       = diff[0];
  assign stat.level     = levels[0];

endmodule

>>> design/key_matrix_change_scanner_unit.sv
// Key matrix change scanner: top level with sequencer and output register.
// Depends on kmcs_pkg, kmcs_level_store and kmcs_line_walker.
//
// Each accepted sense word is compared with the stored levels of the current
// drive row; one event word leaves per changed sense line, lowest line first,
// then a row-end word with the next row's active-low drive pattern. Rows run
// 0 to NUM_ROWS-1 and wrap; reset clears all levels, so keys held at reset
// come out as presses. An input word is accepted only in idle; in_stall is
// high from acceptance until the row-end word has been loaded into the output
// register. The line walker tests one sense line per cycle, held while an
// event word waits on out_stall, and stops once no changed line is left; the
// sequencer then sees no line left and loads the row-end word.
module key_matrix_change_scanner_unit import kmcs_pkg::*; #(
  parameter int NUM_ROWS  = 9,
  parameter int NUM_LINES = 18
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SENSE_W-1:0]    sense_bits,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  event_valid,
  output logic [ROW_IDX_W-1:0]  row_index,
  output logic [LINE_IDX_W-1:0] line_index,
  output logic                  pressed,
  output logic [DRIVE_W-1:0]    drive_pattern,
  output logic                  last_of_run
);

  localparam int ROW_W  = $clog2(NUM_ROWS);
  localparam int LINE_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  kmcs_state_t          state, state_next;
  kmcs_store_ctrl_t     store_ctrl;
  kmcs_walk_ctrl_t      walk_ctrl;
  kmcs_walk_stat_t      walk_stat;
  logic [MAX_LINES-1:0] sense_ext;
  logic [NUM_LINES-1:0] now_levels;
  logic [NUM_LINES-1:0] old_levels;
  logic [ROW_W-1:0]     row;
  logic [ROW_W-1:0]     row_next;
  logic [LINE_W-1:0]    line;
  logic                 out_free;
  logic                 emit_event;
  logic                 emit_end;

  assign sense_ext  = MAX_LINES'(sense_bits);
  assign now_levels = sense_ext[NUM_LINES-1:0];
  assign row_next   = (row == ROW_W'(NUM_ROWS - 1)) ? '0 : row + ROW_W'(1);
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != ST_IDLE);

  kmcs_level_store #(
    .NUM_ROWS  (NUM_ROWS),
    .NUM_LINES (NUM_LINES)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (store_ctrl),
    .new_levels (now_levels),
    .old_levels (old_levels),
    .row        (row)
  );

  kmcs_line_walker #(
    .NUM_LINES (NUM_LINES)
  ) u_walker (
    .clk        (clk),
    .ctrl       (walk_ctrl),
    .new_levels (now_levels),
    .old_levels (old_levels),
    .stat       (walk_stat),
    .line       (line)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    store_ctrl.write   = 1'b0;
    store_ctrl.advance = 1'b0;
    walk_ctrl.load     = 1'b0;
    walk_ctrl.step     = 1'b0;
    emit_event         = 1'b0;
    emit_end           = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          store_ctrl.write = 1'b1;
          walk_ctrl.load   = 1'b1;
          state_next       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (walk_stat.none_left) begin
          state_next = ST_ROWEND;
        end else if (!walk_stat.hit) begin
          walk_ctrl.step = 1'b1;
        end else if (out_free) begin
          emit_event     = 1'b1;
          walk_ctrl.step = 1'b1;
        end
      end
      ST_ROWEND: begin
        if (out_free) begin
          emit_end           = 1'b1;
          store_ctrl.advance = 1'b1;
          state_next         = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_event || emit_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_event) begin
      event_valid   <= 1'b1;
      row_index     <= ROW_IDX_W'(row);
      line_index    <= LINE_IDX_W'(line);
      pressed       <= walk_stat.level;
      drive_pattern <= '0;
      last_of_run   <= 1'b0;
    end else if (emit_end) begin
      event_valid   <= 1'b0;
      row_index     <= ROW_IDX_W'(row);
      line_index    <= '0;
      pressed       <= 1'b0;
      drive_pattern <= drive_for(ROW_IDX_W'(row_next));
      last_of_run   <= 1'b1;
    end
  end

endmodule
